FILE: design/isoep_pkg.sv
// ============================================================================
// isoep_pkg - shared types and constants for the ISO 8601 to epoch-ms block
// Holds the job record that passes from the text parser to the date
// arithmetic, the status codes and the fixed widths of the fields.
// ============================================================================
`default_nettype none

package isoep_pkg;

    // Longest accepted text; a character at this index or beyond is an error.
    localparam int MAX_TEXT_LEN = 32;
    localparam int POS_W        = $clog2(MAX_TEXT_LEN + 1);

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int MILLI_W = 10;
    localparam int DCNT_W  = 3;

    // Text layout
    localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(MAX_TEXT_LEN);
    localparam logic [POS_W-1:0]  POS_ZONE = POS_W'(19);
    localparam logic [DCNT_W-1:0] ZONE_LEN = DCNT_W'(6);

    // Characters
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Depth of the queue between parser and arithmetic
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ZONE   = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [MILLI_W-1:0] milli;
        logic               zone_neg;
        logic [FIELD_W-1:0] zone_hours;
        logic [FIELD_W-1:0] zone_minutes;
        t_status            status;
    } t_job;

    // Queue state seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_flags;

endpackage

`default_nettype wire

FILE: design/isoep_front.sv
// ============================================================================
// isoep_front - character parser
// Takes one character a cycle while the queue is not full, collects the date, time,
// millisecond and zone fields, and hands a finished job with its status to the queue.
// ============================================================================
`default_nettype none

module isoep_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_text_char,
    input  logic                 i_is_last,
    output logic                 o_push,
    output isoep_pkg::t_job      o_job,
    input  isoep_pkg::t_queue_flags i_qflags
);
    import isoep_pkg::*;

    typedef enum logic [4:0] {
        PH_FIELDS    = 5'b00001,
        PH_MILLI     = 5'b00010,
        PH_SKIP      = 5'b00100,
        PH_ZONE_Z    = 5'b01000,
        PH_ZONE_SIGN = 5'b10000
    } t_phase;

    function automatic logic [YEAR_W-1:0] mac10(input logic [YEAR_W-1:0] x,
                                                input logic [3:0] d);
        mac10 = (x << 3) + (x << 1) + YEAR_W'(d);
    endfunction

    logic [POS_W-1:0]   r_pos, n_pos;
    t_phase             r_phase, n_phase;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [FIELD_W-1:0] r_month, n_month, r_day, n_day;
    logic [FIELD_W-1:0] r_hour, n_hour, r_minute, n_minute, r_second, n_second;
    logic [MILLI_W-1:0] r_milli, n_milli;
    logic               r_zone_neg, n_zone_neg;
    logic [FIELD_W-1:0] r_zone_hours, n_zone_hours, r_zone_minutes, n_zone_minutes;
    logic               r_err, n_err;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic               r_too_long, n_too_long;

    logic               w_accept;
    logic               w_dig;
    logic [3:0]         w_dv;
    logic               w_marker;
    t_status            w_status;

    assign o_stall  = i_qflags.full;
    assign w_accept = i_valid && !i_qflags.full;
    assign o_push   = w_accept && i_is_last;

    assign w_dig    = i_text_char inside {[CH_0:CH_9]};
    assign w_dv     = w_dig ? 4'(i_text_char - CH_0) : 4'd0;
    assign w_marker = (i_text_char == CH_Z) || (i_text_char == CH_PLUS) ||
                      (i_text_char == CH_MINUS);

    always_comb begin
        n_pos          = r_pos;
        n_phase        = r_phase;
        n_year         = r_year;
        n_month        = r_month;
        n_day          = r_day;
        n_hour         = r_hour;
        n_minute       = r_minute;
        n_second       = r_second;
        n_milli        = r_milli;
        n_zone_neg     = r_zone_neg;
        n_zone_hours   = r_zone_hours;
        n_zone_minutes = r_zone_minutes;
        n_err          = r_err;
        n_dcnt         = r_dcnt;
        n_too_long     = r_too_long;

        if (r_pos >= POS_MAX) begin
            n_too_long = 1'b1;
        end else begin
            n_pos = r_pos + POS_W'(1);
            if (r_phase == PH_FIELDS && r_pos < POS_ZONE) begin
                // fixed-position date and time digits; separators pass unchecked
                case (r_pos[4:0]) inside
                    5'd0, 5'd1, 5'd2, 5'd3: begin
                        if (w_dig) n_year = mac10(r_year, w_dv);
                        else n_err = 1'b1;
                    end
                    5'd5, 5'd6: begin
                        if (w_dig) n_month = FIELD_W'(mac10(YEAR_W'(r_month), w_dv));
                        else n_err = 1'b1;
                    end
                    5'd8, 5'd9: begin
                        if (w_dig) n_day = FIELD_W'(mac10(YEAR_W'(r_day), w_dv));
                        else n_err = 1'b1;
                    end
                    5'd11, 5'd12: begin
                        if (w_dig) n_hour = FIELD_W'(mac10(YEAR_W'(r_hour), w_dv));
                        else n_err = 1'b1;
                    end
                    5'd14, 5'd15: begin
                        if (w_dig) n_minute = FIELD_W'(mac10(YEAR_W'(r_minute), w_dv));
                        else n_err = 1'b1;
                    end
                    5'd17, 5'd18: begin
                        if (w_dig) n_second = FIELD_W'(mac10(YEAR_W'(r_second), w_dv));
                        else n_err = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else if (r_phase inside {PH_FIELDS, PH_MILLI, PH_SKIP}) begin
                if (w_marker) begin
                    if (r_phase == PH_MILLI && r_dcnt == '0) n_err = 1'b1;
                    n_phase    = (i_text_char == CH_Z) ? PH_ZONE_Z : PH_ZONE_SIGN;
                    n_zone_neg = (i_text_char == CH_MINUS);
                    n_dcnt     = DCNT_W'(1);
                end else if (r_phase == PH_FIELDS) begin
                    n_phase = (i_text_char == CH_DOT) ? PH_MILLI : PH_SKIP;
                    n_dcnt  = '0;
                end else if (r_phase == PH_MILLI) begin
                    if (w_dig) begin
                        n_milli = MILLI_W'(mac10(YEAR_W'(r_milli), w_dv));
                        n_dcnt  = r_dcnt + DCNT_W'(1);
                        if (r_dcnt >= DCNT_W'(2)) n_phase = PH_SKIP;
                    end else begin
                        if (r_dcnt == '0) n_err = 1'b1;
                        n_phase = PH_SKIP;
                    end
                end
            end else if (r_phase == PH_ZONE_Z) begin
                n_err = 1'b1;
            end else begin
                // sign zone: HH, separator, MM
                case (r_dcnt) inside
                    3'd1, 3'd2: begin
                        if (!w_dig) n_err = 1'b1;
                        n_zone_hours = FIELD_W'(mac10(YEAR_W'(r_zone_hours), w_dv));
                    end
                    3'd4, 3'd5: begin
                        if (!w_dig) n_err = 1'b1;
                        n_zone_minutes = FIELD_W'(mac10(YEAR_W'(r_zone_minutes), w_dv));
                    end
                    3'd6, 3'd7: begin
                        n_err = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (r_dcnt < ZONE_LEN) n_dcnt = r_dcnt + DCNT_W'(1);
            end
        end
    end

    always_comb begin
        if (n_too_long) begin
            w_status = ST_MALFORMED;
        end else if (n_phase inside {PH_FIELDS, PH_MILLI, PH_SKIP}) begin
            w_status = ST_NO_ZONE;
        end else if (n_err) begin
            w_status = ST_MALFORMED;
        end else if (n_month < FIELD_W'(1) || n_month > FIELD_W'(12)) begin
            w_status = ST_MALFORMED;
        end else if (n_phase == PH_ZONE_SIGN && n_dcnt != ZONE_LEN) begin
            w_status = ST_MALFORMED;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_job.year         = n_year;
        o_job.month        = n_month;
        o_job.day          = n_day;
        o_job.hour         = n_hour;
        o_job.minute       = n_minute;
        o_job.second       = n_second;
        o_job.milli        = n_milli;
        o_job.zone_neg     = n_zone_neg;
        o_job.zone_hours   = n_zone_hours;
        o_job.zone_minutes = n_zone_minutes;
        o_job.status       = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_is_last)) begin
            r_pos          <= '0;
            r_phase        <= PH_FIELDS;
            r_year         <= '0;
            r_month        <= '0;
            r_day          <= '0;
            r_hour         <= '0;
            r_minute       <= '0;
            r_second       <= '0;
            r_milli        <= '0;
            r_zone_neg     <= 1'b0;
            r_zone_hours   <= '0;
            r_zone_minutes <= '0;
            r_err          <= 1'b0;
            r_dcnt         <= '0;
            r_too_long     <= 1'b0;
        end else if (w_accept) begin
            r_pos          <= n_pos;
            r_phase        <= n_phase;
            r_year         <= n_year;
            r_month        <= n_month;
            r_day          <= n_day;
            r_hour         <= n_hour;
            r_minute       <= n_minute;
            r_second       <= n_second;
            r_milli        <= n_milli;
            r_zone_neg     <= n_zone_neg;
            r_zone_hours   <= n_zone_hours;
            r_zone_minutes <= n_zone_minutes;
            r_err          <= n_err;
            r_dcnt         <= n_dcnt;
            r_too_long     <= n_too_long;
        end
    end

endmodule

`default_nettype wire

FILE: design/isoep_queue.sv
// ============================================================================
// isoep_queue - job queue between parser and date arithmetic
// A short first-in first-out store of parsed jobs.
// ============================================================================
`default_nettype none

module isoep_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  isoep_pkg::t_job          i_job,
    input  logic                     i_pop,
    output isoep_pkg::t_job          o_job,
    output isoep_pkg::t_queue_flags  o_flags
);
    import isoep_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

    t_job               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_flags.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign o_job         = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/isoep_back.sv
// ============================================================================
// isoep_back - date arithmetic sequencer
// Turns one parsed job into epoch milliseconds with a single shared
// multiply-accumulate unit, one step a cycle, and holds the result.
// ============================================================================
`default_nettype none

module isoep_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  isoep_pkg::t_job       i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [48:0]    o_epoch_ms,
    output logic [1:0]            o_status
);
    import isoep_pkg::*;

    localparam int DAYS_W  = 25;
    localparam int ACC_W   = 50;
    localparam int MULA_W  = 25;
    localparam int MULB_W  = 28;
    localparam int RECIP_SHIFT = 20;

    localparam logic signed [MULB_W-1:0] K_YEAR_DAYS = 28'sd365;
    localparam logic signed [MULB_W-1:0] K_RECIP_100 = 28'sd10486;
    localparam logic signed [MULB_W-1:0] K_DAY_MS    = 28'sd86400000;
    localparam logic signed [MULB_W-1:0] K_HOUR_MS   = 28'sd3600000;
    localparam logic signed [MULB_W-1:0] K_MIN_MS    = 28'sd60000;
    localparam logic signed [MULB_W-1:0] K_SEC_MS    = 28'sd1000;
    // days from 0000-03-01 (shifted one 400-year era) to 1970-01-01, plus one
    localparam logic [DAYS_W-1:0]        DAYS_BIAS   = 25'd865566;
    localparam logic [YEAR_W-1:0]        YY_OFFSET   = 14'd400;

    typedef enum logic [11:0] {
        BK_IDLE = 12'b000000000001,
        BK_Y365 = 12'b000000000010,
        BK_Q100 = 12'b000000000100,
        BK_Q400 = 12'b000000001000,
        BK_DAYS = 12'b000000010000,
        BK_MSD  = 12'b000000100000,
        BK_HR   = 12'b000001000000,
        BK_MIN  = 12'b000010000000,
        BK_SEC  = 12'b000100000000,
        BK_ZH   = 12'b001000000000,
        BK_ZM   = 12'b010000000000,
        BK_DONE = 12'b100000000000
    } t_bk_state;

    // days before the first of the month, year taken to start in March
    function automatic logic [8:0] doy_base(input logic [FIELD_W-1:0] month);
        case (month)
            7'd3:    doy_base = 9'd0;
            7'd4:    doy_base = 9'd31;
            7'd5:    doy_base = 9'd61;
            7'd6:    doy_base = 9'd92;
            7'd7:    doy_base = 9'd122;
            7'd8:    doy_base = 9'd153;
            7'd9:    doy_base = 9'd184;
            7'd10:   doy_base = 9'd214;
            7'd11:   doy_base = 9'd245;
            7'd12:   doy_base = 9'd275;
            7'd1:    doy_base = 9'd306;
            7'd2:    doy_base = 9'd337;
            default: doy_base = 9'd0;
        endcase
    endfunction

    t_bk_state                  r_state;
    t_job                       r_job;
    logic [YEAR_W-1:0]          r_yy;
    logic [DAYS_W-1:0]          r_days;
    logic [ACC_W-1:0]           r_acc;
    logic                       r_o_valid;
    logic [48:0]                r_o_epoch;
    t_status                    r_o_status;

    logic signed [MULA_W-1:0]        w_mul_a;
    logic signed [MULB_W-1:0]        w_mul_b;
    logic signed [MULA_W+MULB_W-1:0] w_prod;
    logic [YEAR_W-1:0]               w_quot;
    logic                            w_load;

    assign o_pop      = (r_state == BK_IDLE) && i_job_valid;
    assign w_load     = (r_state == BK_DONE) && (!r_o_valid || !i_stall);
    assign o_valid    = r_o_valid;
    assign o_epoch_ms = $signed(r_o_epoch);
    assign o_status   = r_o_status;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            BK_Y365: begin
                w_mul_a = $signed(MULA_W'(r_yy));
                w_mul_b = K_YEAR_DAYS;
            end
            BK_Q100: begin
                w_mul_a = $signed(MULA_W'(r_yy));
                w_mul_b = K_RECIP_100;
            end
            BK_Q400: begin
                w_mul_a = $signed(MULA_W'(r_yy[YEAR_W-1:2]));
                w_mul_b = K_RECIP_100;
            end
            BK_MSD: begin
                w_mul_a = $signed(r_days);
                w_mul_b = K_DAY_MS;
            end
            BK_HR: begin
                w_mul_a = $signed(MULA_W'(r_job.hour));
                w_mul_b = K_HOUR_MS;
            end
            BK_MIN: begin
                w_mul_a = $signed(MULA_W'(r_job.minute));
                w_mul_b = K_MIN_MS;
            end
            BK_SEC: begin
                w_mul_a = $signed(MULA_W'(r_job.second));
                w_mul_b = K_SEC_MS;
            end
            BK_ZH: begin
                w_mul_a = $signed(MULA_W'(r_job.zone_hours));
                w_mul_b = K_HOUR_MS;
            end
            BK_ZM: begin
                w_mul_a = $signed(MULA_W'(r_job.zone_minutes));
                w_mul_b = K_MIN_MS;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_quot = w_prod[RECIP_SHIFT +: YEAR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                BK_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= (i_job.status == ST_OK) ? BK_Y365 : BK_DONE;
                    end
                end
                BK_Y365: r_state <= BK_Q100;
                BK_Q100: r_state <= BK_Q400;
                BK_Q400: r_state <= BK_DAYS;
                BK_DAYS: r_state <= BK_MSD;
                BK_MSD:  r_state <= BK_HR;
                BK_HR:   r_state <= BK_MIN;
                BK_MIN:  r_state <= BK_SEC;
                BK_SEC:  r_state <= BK_ZH;
                BK_ZH:   r_state <= BK_ZM;
                BK_ZM:   r_state <= BK_DONE;
                BK_DONE: begin
                    if (w_load) r_state <= BK_IDLE;
                end
                default: r_state <= BK_IDLE;
            endcase
            if (w_load) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                    // shift one era forward so that every quotient is non-negative
                    r_yy  <= i_job.year + YY_OFFSET -
                             YEAR_W'(i_job.month <= FIELD_W'(2));
                end
            end
            BK_Y365: r_days <= DAYS_W'(w_prod);
            BK_Q100: r_days <= r_days - DAYS_W'(w_quot);
            BK_Q400: r_days <= r_days + DAYS_W'(w_quot);
            BK_DAYS: r_days <= r_days + DAYS_W'(r_yy[YEAR_W-1:2]) +
                               DAYS_W'(doy_base(r_job.month)) +
                               DAYS_W'(r_job.day) - DAYS_BIAS;
            BK_MSD:  r_acc <= w_prod[ACC_W-1:0] + ACC_W'(r_job.milli);
            BK_HR, BK_MIN, BK_SEC: r_acc <= r_acc + w_prod[ACC_W-1:0];
            BK_ZH, BK_ZM: begin
                if (r_job.zone_neg) r_acc <= r_acc + w_prod[ACC_W-1:0];
                else r_acc <= r_acc - w_prod[ACC_W-1:0];
            end
            BK_DONE: begin
                if (w_load) begin
                    r_o_epoch  <= (r_job.status == ST_OK) ? r_acc[48:0] : '0;
                    r_o_status <= r_job.status;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/iso8601_text_to_epoch_ms.sv
// ============================================================================
// iso8601_text_to_epoch_ms - ISO 8601 timestamp text to Unix epoch ms
// Streams timestamp text in a byte at a time and returns signed epoch
// milliseconds with a status for each timestamp.
// ============================================================================
// Feed the text one ASCII byte per item, first character first, with
// i_is_last set on the final byte; exactly one result comes back per
// timestamp, none for the other bytes. The layout is fixed: year at 0-3,
// month 5-6, day 8-9, hour 11-12, minute 14-15, second 17-18, then an
// optional '.' with up to three millisecond digits (taken at face value),
// then 'Z' or a signed HH:MM offset that is subtracted. Status 0 is good,
// 1 means no zone marker was found, 2 means malformed or over-long text;
// o_epoch_ms is zero whenever status is not 0. Rate: the parser takes one
// byte every cycle while o_stall is low. The date arithmetic runs on one
// shared multiply-accumulate unit and steps through BK_Y365 to BK_ZM for a
// good timestamp, but goes from BK_IDLE straight to BK_DONE for a rejected
// one; a two-entry job queue sits between them, so the parser can take the
// next text while a job is converted, and o_stall holds it back only while
// the queue is full. A result waits in the output register while the next
// text is being parsed. o_valid rises when BK_DONE loads that register.
// ============================================================================
`default_nettype none

module iso8601_text_to_epoch_ms (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_text_char,
    input  logic                i_is_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [48:0]  o_epoch_ms,
    output logic [1:0]          o_status
);
    import isoep_pkg::*;

    logic          w_push;
    logic          w_pop;
    t_job          w_front_job;
    t_job          w_queue_job;
    t_queue_flags  w_qflags;

    // Parse characters and emit one job per timestamp
    isoep_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_char (i_text_char),
        .i_is_last   (i_is_last),
        .o_push      (w_push),
        .o_job       (w_front_job),
        .i_qflags    (w_qflags)
    );

    // Hold parsed jobs so parsing and arithmetic stall independently
    isoep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_queue_job),
        .o_flags (w_qflags)
    );

    // Convert each job to epoch milliseconds and present the result
    isoep_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_qflags.empty),
        .i_job       (w_queue_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_epoch_ms  (o_epoch_ms),
        .o_status    (o_status)
    );

    // A job is never pushed into a full queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qflags.full)
        else $error("job pushed into a full queue");

    // The arithmetic side only pops a job that is present
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qflags.empty)
        else $error("job popped from an empty queue");

    // A rejected timestamp always reports zero milliseconds
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_epoch_ms == '0))
        else $error("non-zero epoch on an error result");

    // A pushed job reaches the arithmetic side no earlier than the next cycle
    a_pop_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qflags.empty && !w_push) |=> !w_pop)
        else $error("job popped without having been pushed");

endmodule

`default_nettype wire
